// ===== rtl/pps_pkg.sv =====
`default_nettype none

package pps_pkg;

    // Table and time sizing
    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int COUNT_W   = $clog2(MAX_PROCS + 1);
    localparam int CMP_W     = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Field widths of the beats
    localparam int ARR_W  = 16;
    localparam int BRST_W = 16;
    localparam int PRIO_W = 8;
    localparam int OUT_W  = 16;
    localparam int ID_W   = 4;

    // Request codes
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } state_t;

    // One slot of the job table
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [BRST_W-1:0] burst;
        logic [BRST_W-1:0] remaining;
        logic [PRIO_W-1:0] prio;
    } job_t;

    // One result beat
    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  slot_id;
        logic             ran;
        logic             finished;
        logic [OUT_W-1:0] completion_time;
        logic [OUT_W-1:0] turnaround_time;
        logic [OUT_W-1:0] waiting_time;
        logic             all_done;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/pps_if.sv =====
`default_nettype none

interface pps_req_if
    import pps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [ARR_W-1:0]  arrival_time;
    logic [BRST_W-1:0] burst_time;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, action, arrival_time, burst_time, priority_req,
                    input ready);
    modport sink   (input valid, action, arrival_time, burst_time, priority_req,
                    output ready);
endinterface

interface pps_rsp_if
    import pps_pkg::*;
();
    logic             valid;
    logic             ready;
    status_t          status;
    logic [ID_W-1:0]  slot_id;
    logic             ran;
    logic             finished;
    logic [OUT_W-1:0] completion_time;
    logic [OUT_W-1:0] turnaround_time;
    logic [OUT_W-1:0] waiting_time;
    logic             all_done;

    modport source (output valid, status, slot_id, ran, finished, completion_time,
                    turnaround_time, waiting_time, all_done,
                    input ready);
    modport sink   (input valid, status, slot_id, ran, finished, completion_time,
                    turnaround_time, waiting_time, all_done,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/preemptive_priority_scheduler.sv =====
// Add beat: the result is registered at acceptance; the next beat is accepted no earlier than the result is taken.
// Tick beat: one table read per cycle through a single comparator; the scan reads each
// job in the table, then the drain and finish steps register the result (an empty
// table goes straight to the finish step). No new beat is accepted while a tick is in progress.
// Reset (rst_n low, asynchronous): time, job and done counts clear; table is not cleared.
`default_nettype none

module preemptive_priority_scheduler
    import pps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pps_req_if.sink   req,
    pps_rsp_if.source rsp
);

    // Control state
    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [SLOT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic                 found_reg, found_next;
    logic [COUNT_W-1:0]   job_count_reg, job_count_next;
    logic [COUNT_W-1:0]   done_count_reg, done_count_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload state
    job_t                 best_reg, best_next;
    logic [SLOT_W-1:0]    best_slot_reg, best_slot_next;
    rsp_t                 out_reg, out_next;

    // Job table
    job_t                 mem [MAX_PROCS];
    job_t                 rd_q;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_wa;
    job_t                 mem_wd;

    logic                 req_ready;
    logic                 cand_ok;
    logic                 cand_better;
    logic [BRST_W-1:0]    new_rem;
    logic [CMP_W-1:0]     tat;
    logic [CMP_W-1:0]     wt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    // Shared compare unit: judge the slot read last cycle against the best so far
    always_comb
    begin
        cand_ok = (CMP_W'(rd_q.arrival) <= CMP_W'(time_reg)) && (rd_q.remaining != '0);
        cand_better = !found_reg
                      || (rd_q.prio < best_reg.prio)
                      || ((rd_q.prio == best_reg.prio) && (rd_q.arrival < best_reg.arrival));
    end

    // Finish arithmetic for the selected job
    always_comb
    begin
        new_rem = best_reg.remaining - BRST_W'(1);
        tat     = CMP_W'(time_next) - CMP_W'(best_reg.arrival);
        wt      = (tat >= CMP_W'(best_reg.burst)) ? tat - CMP_W'(best_reg.burst) : '0;
    end

    assign req_ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req.ready = req_ready;

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        job_count_next  = job_count_reg;
        done_count_next = done_count_reg;
        time_next       = time_reg;
        out_valid_next  = out_valid_reg;
        best_next       = best_reg;
        best_slot_next  = best_slot_reg;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        mem_we          = 1'b0;
        mem_wa          = job_count_reg[SLOT_W-1:0];
        mem_wd          = best_reg;

        // drop the result beat once taken
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // keep the better candidate
        if (rd_vld_reg && cand_ok && cand_better)
        begin
            found_next     = 1'b1;
            best_next      = rd_q;
            best_slot_next = rd_idx_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req_ready)
                begin
                    if (req.action == ACT_ADD)
                    begin
                        out_next          = '0;
                        out_valid_next    = 1'b1;
                        if (job_count_reg >= COUNT_W'(MAX_PROCS))
                        begin
                            out_next.status = ST_FULL;
                        end
                        else if (req.burst_time == '0)
                        begin
                            out_next.status = ST_ZERO;
                        end
                        else
                        begin
                            mem_we            = 1'b1;
                            mem_wd.arrival    = req.arrival_time;
                            mem_wd.burst      = req.burst_time;
                            mem_wd.remaining  = req.burst_time;
                            mem_wd.prio       = req.priority_req;
                            out_next.status   = ST_OK;
                            out_next.slot_id  = ID_W'(job_count_reg[SLOT_W-1:0]);
                            job_count_next    = job_count_reg + COUNT_W'(1);
                        end
                        out_next.all_done = (done_count_reg == job_count_next);
                    end
                    else
                    begin
                        found_next = 1'b0;
                        idx_next   = '0;
                        state_next = (job_count_reg == '0) ? S_FIN : S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one table read per cycle
                rd_en       = 1'b1;
                rd_idx_next = idx_reg;
                idx_next    = idx_reg + SLOT_W'(1);
                if ((COUNT_W'(idx_reg) + COUNT_W'(1)) == job_count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_FIN;
            end

            S_FIN:
            begin
                time_next      = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_BITS'(1);
                out_next       = '0;
                out_next.status = ST_OK;
                out_valid_next = 1'b1;
                if (found_reg)
                begin
                    // write back the used tick
                    mem_we           = 1'b1;
                    mem_wa           = best_slot_reg;
                    mem_wd.remaining = new_rem;
                    out_next.slot_id = ID_W'(best_slot_reg);
                    out_next.ran     = 1'b1;
                    if (new_rem == '0)
                    begin
                        done_count_next          = done_count_reg + COUNT_W'(1);
                        out_next.finished        = 1'b1;
                        out_next.completion_time = OUT_W'(time_next);
                        out_next.turnaround_time = OUT_W'(tat);
                        out_next.waiting_time    = OUT_W'(wt);
                    end
                end
                out_next.all_done = (done_count_next == job_count_reg);
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_vld_next = rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            rd_idx_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            job_count_reg  <= '0;
            done_count_reg <= '0;
            time_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rd_idx_reg     <= rd_idx_next;
            rd_vld_reg     <= rd_vld_next;
            found_reg      <= found_next;
            job_count_reg  <= job_count_next;
            done_count_reg <= done_count_next;
            time_reg       <= time_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        out_reg       <= out_next;
    end

    // Drive the result beat
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.slot_id         = out_reg.slot_id;
    assign rsp.ran             = out_reg.ran;
    assign rsp.finished        = out_reg.finished;
    assign rsp.completion_time = out_reg.completion_time;
    assign rsp.turnaround_time = out_reg.turnaround_time;
    assign rsp.waiting_time    = out_reg.waiting_time;
    assign rsp.all_done        = out_reg.all_done;

`ifndef SYNTHESIS
    // no result may be pending while a tick is in progress
    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending during tick");

    // completed jobs never outnumber added jobs
    a_done_le_jobs: assert property (@(posedge clk) disable iff (!rst_n)
        done_count_reg <= job_count_reg)
        else $error("done count exceeds job count");

    // an accepted tick starts a scan, or finishes at once on an empty table
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req_ready && (req.action == ACT_TICK))
        |=> ((state_reg == S_SCAN) || (state_reg == S_FIN)))
        else $error("tick did not start a scan");

    // the finish step always leaves a result beat
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finish step left no result");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int          ARR_MAX      = 2**ARR_W - 1;
    localparam int          RANDOM_ITEMS = 370;
    localparam int          RANDOM_CAP   = MAX_PROCS - 2;
    localparam int          LONG_HOLD    = 200;
    localparam int          MAX_REPORTS  = 100;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pps_req_if req_bus ();
    pps_rsp_if rsp_bus ();

    preemptive_priority_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    // Scheduler state as the testbench tracks it
    logic [TIME_BITS-1:0] sched_time = '0;
    int unsigned          jobs_added = 0;
    int unsigned          jobs_done  = 0;
    logic [ARR_W-1:0]     job_arr  [MAX_PROCS];
    logic [BRST_W-1:0]    job_len  [MAX_PROCS];
    logic [BRST_W-1:0]    job_left [MAX_PROCS];
    logic [PRIO_W-1:0]    job_prio [MAX_PROCS];

    rsp_t        pending_outcomes [$];
    int unsigned mismatches       = 0;
    int unsigned cycle_count      = 0;
    bit          traffic_gaps     = 1'b1;
    int          rsp_hold_request = 0;

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one beat to the tracked table and return the outcome it should give
    function automatic rsp_t schedule_step(logic act, logic [ARR_W-1:0] arr,
                                           logic [BRST_W-1:0] brst,
                                           logic [PRIO_W-1:0] prio);
        rsp_t        r;
        bit          found;
        int unsigned pick;
        int unsigned span;
        r      = '0;
        r.status = ST_OK;
        found  = 1'b0;
        pick   = 0;
        if (act == ACT_ADD)
        begin
            if (jobs_added >= MAX_PROCS)
            begin
                r.status = ST_FULL;
            end
            else if (brst == '0)
            begin
                r.status = ST_ZERO;
            end
            else
            begin
                job_arr[jobs_added]  = arr;
                job_len[jobs_added]  = brst;
                job_left[jobs_added] = brst;
                job_prio[jobs_added] = prio;
                r.slot_id            = ID_W'(jobs_added);
                jobs_added++;
            end
        end
        else
        begin
            // Pick the ready job: lowest priority number, then earliest arrival, then slot
            for (int i = 0; i < jobs_added; i++)
            begin
                if (job_arr[i] <= sched_time && job_left[i] != '0)
                begin
                    if (!found || job_prio[i] < job_prio[pick] ||
                        (job_prio[i] == job_prio[pick] && job_arr[i] < job_arr[pick]))
                        pick = i;
                    found = 1'b1;
                end
            end
            // Advance time, holding at the top
            if (sched_time != TIME_MAX)
                sched_time = sched_time + 1'b1;
            if (found)
            begin
                job_left[pick] = job_left[pick] - 1'b1;
                r.ran     = 1'b1;
                r.slot_id = ID_W'(pick);
                if (job_left[pick] == '0)
                begin
                    span = int'(sched_time) - int'(job_arr[pick]);
                    r.finished        = 1'b1;
                    r.completion_time = OUT_W'(sched_time);
                    r.turnaround_time = OUT_W'(span);
                    r.waiting_time    = (span >= job_len[pick]) ? OUT_W'(span - job_len[pick]) : '0;
                    jobs_done++;
                end
            end
        end
        r.all_done = (jobs_done == jobs_added);
        return r;
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_beat(logic act, logic [ARR_W-1:0] arr, logic [BRST_W-1:0] brst,
                             logic [PRIO_W-1:0] prio);
        int gap;
        gap = traffic_gaps ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.action       <= act;
        req_bus.arrival_time <= arr;
        req_bus.burst_time   <= brst;
        req_bus.priority_req <= prio;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
            @(posedge clk);
        pending_outcomes.push_back(schedule_step(act, arr, brst, prio));
    endtask

    // Tick fields carry noise; the block must ignore them
    task automatic send_tick();
        send_beat(ACT_TICK, ARR_W'($urandom), BRST_W'($urandom), PRIO_W'($urandom));
    endtask

    // Add a job that arrives near the current time, sometimes much later
    task automatic send_random_job();
        int                a;
        logic [BRST_W-1:0] b;
        logic [PRIO_W-1:0] p;
        if ($urandom_range(0, 9) == 0)
            a = $urandom_range(int'(sched_time), ARR_MAX);
        else
            a = int'(sched_time) + int'($urandom_range(0, 40)) - 12;
        if (a > ARR_MAX)
            a = ARR_MAX;
        if (a < 0)
            a = 0;
        b = ($urandom_range(0, 4) == 0) ? BRST_W'($urandom_range(9, 60))
                                        : BRST_W'($urandom_range(1, 8));
        p = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3))
                                 : PRIO_W'($urandom_range(0, 255));
        send_beat(ACT_ADD, ARR_W'(a), b, p);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_all_results();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_tick();
        send_beat(ACT_ADD, 16'h1234, '0, 8'h5A);
    endtask

    // Future arrival, preemption, ties on priority and on arrival, late add
    task automatic test_scheduling_order();
        send_beat(ACT_ADD, 16'd4, 16'd3, 8'd255);
        send_beat(ACT_ADD, 16'd6, 16'd2, 8'd0);
        send_beat(ACT_ADD, 16'd5, 16'd2, 8'd0);
        send_beat(ACT_ADD, 16'd6, 16'd1, 8'd0);
        repeat (2) send_tick();
        send_beat(ACT_ADD, 16'd0, 16'd2, 8'd128);
        repeat (12) send_tick();
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // Leave a stretch with no idling on either side
            traffic_gaps = !(k >= 150 && k < 200);
            if ($urandom_range(0, 99) < 7)
            begin
                if (jobs_added < RANDOM_CAP && $urandom_range(0, 5) != 0)
                    send_random_job();
                else
                    send_beat(ACT_ADD, ARR_W'($urandom), '0, PRIO_W'($urandom));
            end
            else
            begin
                send_tick();
            end
        end
        traffic_gaps = 1'b1;
        wait_all_results();
    endtask

    // Block results for a long stretch while beats keep coming
    task automatic test_output_backpressure();
        traffic_gaps     = 1'b0;
        rsp_hold_request = LONG_HOLD;
        repeat (10) send_tick();
        wait_all_results();
        traffic_gaps = 1'b1;
    endtask

    // Fill the table (fixed adds take the last two slots), then try adds refused as full
    task automatic test_table_full();
        while (jobs_added < RANDOM_CAP)
            send_random_job();
        send_beat(ACT_ADD, 16'hFFFF, 16'd3, 8'd0);
        send_beat(ACT_ADD, 16'hFFFF, 16'hFFFF, 8'd255);
        send_beat(ACT_ADD, 16'h00FF, '0, 8'd7);
        send_beat(ACT_ADD, ARR_W'($urandom), BRST_W'($urandom), PRIO_W'($urandom));
        repeat (30) send_tick();
        wait_all_results();
    endtask

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            // Keep the log readable on a broken design
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d actual %0d", $time, fname, want, got);
        end
    endtask

    // Result side: random stalls plus one long hold on request
    initial
    begin : rsp_sink
        int stall_left;
        stall_left    = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_request > 0)
            begin
                stall_left       = rsp_hold_request;
                rsp_hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (traffic_gaps && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare each result beat with the oldest outcome waiting
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result beat with none expected: expected none actual slot %0d",
                             $time, rsp_bus.slot_id);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("status", want.status, rsp_bus.status);
                check_field("slot_id", want.slot_id, rsp_bus.slot_id);
                check_field("ran", want.ran, rsp_bus.ran);
                check_field("finished", want.finished, rsp_bus.finished);
                check_field("completion_time", want.completion_time, rsp_bus.completion_time);
                check_field("turnaround_time", want.turnaround_time, rsp_bus.turnaround_time);
                check_field("waiting_time", want.waiting_time, rsp_bus.waiting_time);
                check_field("all_done", want.all_done, rsp_bus.all_done);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        req_bus.valid        = 1'b0;
        req_bus.action       = ACT_TICK;
        req_bus.arrival_time = '0;
        req_bus.burst_time   = '0;
        req_bus.priority_req = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_scheduling_order();
        test_random_traffic();
        test_output_backpressure();
        test_table_full();

        // Let any stray beat show up before the verdict
        wait_all_results();
        repeat (MAX_PROCS + 8) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
